// ===== rtl/bowg_pkg.sv =====
// Shared constants and widths of the bilinear offset weight generator.
package bowg_pkg;

  // Fraction bits of the incoming shifts and of the weights
  localparam int FRAC_BITS = 12;
  localparam int FRAC_W    = FRAC_BITS + 1;           // holds 0 .. 2^FRAC_BITS

  localparam int SHIFT_W   = 24;
  localparam int SIZE_W    = 16;
  localparam int WEIGHT_W  = 13;
  localparam int OFFSET_W  = 13;
  localparam int START_W   = 12;
  localparam int END_W     = 17;

  localparam int IN_DATA_W  = 2 * SHIFT_W;
  localparam int OUT_DATA_W = 4 * WEIGHT_W + 2 * OFFSET_W + 2 * START_W + 2 * END_W;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_SAMPLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AZIMUTH_LINES = 2'd1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd4096;

endpackage

// ===== rtl/bilinear_offset_weight_gen.sv =====
// Top level: bilinear weights, neighbour offsets and valid bounds from shift pairs.
//
// Takes one range position per transfer: a range and an azimuth shift, signed fixed
// point with FRAC_BITS fraction bits, plus a first-item flag on tuser and the last
// item on tlast. Each shift is split into an integer part truncated toward zero and
// a fraction; the block returns the four bilinear weights (1-t)(1-u), t(1-u), t*u and
// (1-t)u in Q1.12 with truncated products, and the left-column and lower-row
// neighbour offsets (right column and upper row are these plus one). A running
// minimum and maximum of the azimuth shift and the range shift of the first item are
// kept; on the last item (output tlast) the valid range and azimuth bounds follow
// with the result, taken from the state after this item has updated it, and are zero
// otherwise. One transfer in and one out per cycle are sustained while the output is
// not stalled: an input register feeds the four 13x13 multipliers and the min/max
// compare, whose result lands in the output register. The output register is refilled in
// the same cycle it is drained. Configuration writes (range_samples, azimuth_lines)
// are always ready and should only be issued while the block is empty.
module bilinear_offset_weight_gen (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bowg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bowg_pkg::SIZE_W-1:0]        cfg_data_i,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: delta_range[23:0], delta_azimuth[47:24]
  input  logic [bowg_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: first_item
  input  logic                               s_axis_tuser,
  input  logic                               s_axis_tlast,    // last_item
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: weight_one[12:0], weight_two[25:13], weight_three[38:26],
  //        weight_four[51:39], column_left[64:52], row_down[77:65],
  //        start_range[89:78], end_range[106:90], start_azimuth[118:107],
  //        end_azimuth[135:119]
  output logic [bowg_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast     // bounds_valid
);

  import bowg_pkg::*;

  localparam logic [FRAC_W-1:0] ONE = FRAC_W'(1) << FRAC_BITS;
  localparam int PROD_W = 2 * FRAC_W;
  localparam int SUM_W  = ((SIZE_W + FRAC_BITS > SHIFT_W) ? SIZE_W + FRAC_BITS : SHIFT_W) + 1;

  typedef struct packed {
    logic [FRAC_W-1:0]   frac;     // t or u, 0 .. ONE
    logic [OFFSET_W-1:0] offset;   // low-side neighbour offset
  } split_t;

  // Integer part toward zero and fraction; offset is -I-1 for a positive shift, else -I
  function automatic split_t split_shift(logic signed [SHIFT_W-1:0] d);
    logic [FRAC_BITS-1:0]          low;
    logic                          pos;
    logic                          nz;
    logic signed [SHIFT_W-1:0]     flr;
    split_t                        r;
    low      = d[FRAC_BITS-1:0];
    pos      = !d[SHIFT_W-1] && (d != '0);
    nz       = (low != '0);
    flr      = d >>> FRAC_BITS;
    r.frac   = (pos || nz) ? ONE - {1'b0, low} : '0;
    r.offset = -OFFSET_W'(flr) - ((pos || (d[SHIFT_W-1] && nz)) ? OFFSET_W'(1) : '0);
    return r;
  endfunction

  function automatic logic [START_W-1:0] start_bound(logic signed [SHIFT_W-1:0] s);
    logic signed [SHIFT_W-1:0] flr;
    flr = s >>> FRAC_BITS;
    if (!s[SHIFT_W-1] && (s != '0)) begin
      return START_W'(flr) + START_W'(1);
    end
    return '0;
  endfunction

  function automatic logic [END_W-1:0] end_bound(logic [SIZE_W-1:0] size,
                                                 logic signed [SHIFT_W-1:0] s);
    logic signed [SUM_W-1:0] sum;
    sum = $signed({{(SUM_W-SIZE_W-FRAC_BITS){1'b0}}, size, {FRAC_BITS{1'b0}}})
        + SUM_W'(s);
    if (!s[SHIFT_W-1]) begin
      return END_W'(size);
    end
    if (sum[SUM_W-1]) begin
      return '0;
    end
    return END_W'(sum >>> FRAC_BITS);
  endfunction

  // configuration
  logic [SIZE_W-1:0] range_samples_q, azimuth_lines_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_samples_q <= SIZE_RESET;
      azimuth_lines_q <= SIZE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RANGE_SAMPLES: range_samples_q <= cfg_data_i;
        CFG_AZIMUTH_LINES: azimuth_lines_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic                      in_valid_q;
  logic signed [SHIFT_W-1:0] dr_q, da_q;
  logic                      first_q, last_q;
  logic                      out_valid_q;
  logic                      advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      dr_q    <= $signed(s_axis_tdata[SHIFT_W-1:0]);
      da_q    <= $signed(s_axis_tdata[2*SHIFT_W-1:SHIFT_W]);
      first_q <= s_axis_tuser;
      last_q  <= s_axis_tlast;
    end
  end

  // running shift state, updated as an item moves to the output register
  logic signed [SHIFT_W-1:0] min_az_q, max_az_q, first_rg_q;
  logic signed [SHIFT_W-1:0] min_az_d, max_az_d, first_rg_d;

  always_comb begin
    if (first_q) begin
      min_az_d   = da_q;
      max_az_d   = da_q;
      first_rg_d = dr_q;
    end else begin
      min_az_d   = (da_q < min_az_q) ? da_q : min_az_q;
      max_az_d   = (da_q > max_az_q) ? da_q : max_az_q;
      first_rg_d = first_rg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_az_q   <= {1'b0, {(SHIFT_W-1){1'b1}}};
      max_az_q   <= {1'b1, {(SHIFT_W-1){1'b0}}};
      first_rg_q <= '0;
    end else if (advance) begin
      min_az_q   <= min_az_d;
      max_az_q   <= max_az_d;
      first_rg_q <= first_rg_d;
    end
  end

  // weights and offsets
  split_t            sp_r, sp_a;
  logic [FRAC_W-1:0] ct, cu;
  logic [PROD_W-1:0] p1, p2, p3, p4;
  logic [OUT_DATA_W-1:0] data_d;
  logic [START_W-1:0] start_range, start_az;
  logic [END_W-1:0]   end_range, end_az;

  always_comb begin
    sp_r = split_shift(dr_q);
    sp_a = split_shift(da_q);
    ct   = ONE - sp_r.frac;
    cu   = ONE - sp_a.frac;
    p1   = PROD_W'(ct) * PROD_W'(cu);
    p2   = PROD_W'(sp_r.frac) * PROD_W'(cu);
    p3   = PROD_W'(sp_r.frac) * PROD_W'(sp_a.frac);
    p4   = PROD_W'(ct) * PROD_W'(sp_a.frac);

    if (last_q) begin
      start_range = start_bound(first_rg_d);
      end_range   = end_bound(range_samples_q, first_rg_d);
      start_az    = start_bound(max_az_d);
      end_az      = end_bound(azimuth_lines_q, min_az_d);
    end else begin
      start_range = '0;
      end_range   = '0;
      start_az    = '0;
      end_az      = '0;
    end

    data_d = {end_az, start_az, end_range, start_range,
              sp_a.offset, sp_r.offset,
              WEIGHT_W'(p4 >> FRAC_BITS), WEIGHT_W'(p3 >> FRAC_BITS),
              WEIGHT_W'(p2 >> FRAC_BITS), WEIGHT_W'(p1 >> FRAC_BITS)};
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_last_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= data_d;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== tb/bilinear_offset_weight_gen_test.sv =====
// Self-checking testbench of the bilinear offset weight generator.
module bilinear_offset_weight_gen_test;
  import bowg_pkg::*;

  localparam longint ONE       = longint'(1) << FRAC_BITS;
  localparam int     QUIET_MAX = 5000;   // cycles with no transfer at all before giving up

  typedef struct {
    logic signed [SHIFT_W-1:0] range_shift;
    logic signed [SHIFT_W-1:0] azimuth_shift;
    logic                      first_pos;
    logic                      last_pos;
  } shift_item_t;

  typedef struct {
    logic [WEIGHT_W-1:0] weight_one;
    logic [WEIGHT_W-1:0] weight_two;
    logic [WEIGHT_W-1:0] weight_three;
    logic [WEIGHT_W-1:0] weight_four;
    logic [OFFSET_W-1:0] column_left;
    logic [OFFSET_W-1:0] row_down;
    logic                bounds_valid;
    logic [START_W-1:0]  start_range;
    logic [END_W-1:0]    end_range;
    logic [START_W-1:0]  start_azimuth;
    logic [END_W-1:0]    end_azimuth;
  } bilinear_result_t;

  // DUT ports, inputs all known from time zero
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = CFG_RANGE_SAMPLES;
  logic [SIZE_W-1:0]     cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  // Predictor copy of the block's registers and running state
  logic [SIZE_W-1:0]         range_size    = SIZE_RESET;
  logic [SIZE_W-1:0]         azimuth_size  = SIZE_RESET;
  logic signed [SHIFT_W-1:0] min_azimuth   = {1'b0, {(SHIFT_W-1){1'b1}}};
  logic signed [SHIFT_W-1:0] max_azimuth   = {1'b1, {(SHIFT_W-1){1'b0}}};
  logic signed [SHIFT_W-1:0] first_range   = '0;

  shift_item_t      pending_shifts[$];   // filled by the stimulus, drained by the driver
  bilinear_result_t weight_sets[$];      // predicted results awaiting their transfer
  shift_item_t      in_flight;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int errors       = 0;
  int shifts_sent  = 0;
  int results_seen = 0;
  int bounds_seen  = 0;
  int reg_writes   = 0;
  int quiet_cycles = 0;

  bilinear_offset_weight_gen uut (.*);

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Integer part toward zero; t or u is the distance to the low-side neighbour
  function automatic void split_shift(input logic signed [SHIFT_W-1:0] d,
                                      output longint frac, output longint offs);
    longint dl;
    longint ip;
    dl = longint'(d);
    ip = dl / ONE;                     // SV signed division truncates toward zero
    if (dl > 0) begin
      frac = ONE - (dl - ip * ONE);
      offs = -ip - 1;
    end else begin
      frac = -(dl - ip * ONE);
      offs = -ip;
    end
  endfunction

  function automatic logic [START_W-1:0] start_limit(input logic signed [SHIFT_W-1:0] sh);
    longint sl;
    sl = longint'(sh);
    if (sl > 0) return START_W'(sl / ONE + 1);
    return '0;
  endfunction

  // Image size less a negative shift, clamped at zero
  function automatic logic [END_W-1:0] end_limit(input logic [SIZE_W-1:0] size,
                                                 input logic signed [SHIFT_W-1:0] sh);
    longint total;
    if (sh >= 0) return END_W'(size);
    total = longint'(size) * ONE + longint'(sh);
    if (total < 0) return '0;
    return END_W'(total >> FRAC_BITS);
  endfunction

  function automatic bilinear_result_t interp_weights(input shift_item_t it);
    bilinear_result_t r;
    longint t, u, col, row, ct, cu;
    // Running state first: bounds are taken after this item has updated it
    if (it.first_pos) begin
      min_azimuth = it.azimuth_shift;
      max_azimuth = it.azimuth_shift;
      first_range = it.range_shift;
    end else begin
      if (it.azimuth_shift < min_azimuth) min_azimuth = it.azimuth_shift;
      if (it.azimuth_shift > max_azimuth) max_azimuth = it.azimuth_shift;
    end
    split_shift(it.range_shift, t, col);
    split_shift(it.azimuth_shift, u, row);
    ct = ONE - t;
    cu = ONE - u;
    r.weight_one   = WEIGHT_W'((ct * cu) >> FRAC_BITS);
    r.weight_two   = WEIGHT_W'((t * cu) >> FRAC_BITS);
    r.weight_three = WEIGHT_W'((t * u) >> FRAC_BITS);
    r.weight_four  = WEIGHT_W'((ct * u) >> FRAC_BITS);
    r.column_left  = col[OFFSET_W-1:0];
    r.row_down     = row[OFFSET_W-1:0];
    r.bounds_valid = it.last_pos;
    if (it.last_pos) begin
      r.start_range   = start_limit(first_range);
      r.end_range     = end_limit(range_size, first_range);
      r.start_azimuth = start_limit(max_azimuth);
      r.end_azimuth   = end_limit(azimuth_size, min_azimuth);
    end else begin
      r.start_range   = '0;
      r.end_range     = '0;
      r.start_azimuth = '0;
      r.end_azimuth   = '0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents the queued shift pairs, holding each until its transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        weight_sets.push_back(interp_weights(in_flight));
        shifts_sent++;
      end
      // slot free: either nothing shown or it has just gone
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_shifts.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_flight = pending_shifts.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {in_flight.azimuth_shift, in_flight.range_shift};
          s_axis_tuser  <= in_flight.first_pos;
          s_axis_tlast  <= in_flight.last_pos;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, every result transfer checked in order
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [END_W-1:0] exp_v,
                             input logic [END_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    bilinear_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (weight_sets.size() == 0) begin
          $display("%0t: result with no prediction pending, tdata 0x%0h", $time,
                   m_axis_tdata);
          errors++;
        end else begin
          want = weight_sets.pop_front();
          check_field("weight_one", END_W'(want.weight_one),
                      END_W'(m_axis_tdata[12:0]));
          check_field("weight_two", END_W'(want.weight_two),
                      END_W'(m_axis_tdata[25:13]));
          check_field("weight_three", END_W'(want.weight_three),
                      END_W'(m_axis_tdata[38:26]));
          check_field("weight_four", END_W'(want.weight_four),
                      END_W'(m_axis_tdata[51:39]));
          check_field("column_left", END_W'(want.column_left),
                      END_W'(m_axis_tdata[64:52]));
          check_field("row_down", END_W'(want.row_down),
                      END_W'(m_axis_tdata[77:65]));
          check_field("bounds_valid", END_W'(want.bounds_valid),
                      END_W'(m_axis_tlast));
          check_field("start_range", END_W'(want.start_range),
                      END_W'(m_axis_tdata[89:78]));
          check_field("end_range", want.end_range, m_axis_tdata[106:90]);
          check_field("start_azimuth", END_W'(want.start_azimuth),
                      END_W'(m_axis_tdata[118:107]));
          check_field("end_azimuth", want.end_azimuth, m_axis_tdata[135:119]);
          results_seen++;
          if (m_axis_tlast) bounds_seen++;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog: any transfer on any channel counts as progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("%0t: no transfer for %0d cycles, %0d predictions outstanding", $time,
                 quiet_cycles, weight_sets.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_shift(input int dr, input int da, input bit first_pos,
                            input bit last_pos);
    shift_item_t it;
    it.range_shift   = SHIFT_W'(dr);
    it.azimuth_shift = SHIFT_W'(da);
    it.first_pos     = first_pos;
    it.last_pos      = last_pos;
    pending_shifts.push_back(it);
  endtask

  // Mix of full-range shifts, shifts near zero and ones at or beside whole samples
  function automatic int rand_shift();
    case ($urandom_range(3))
      0:       return int'($urandom);
      1:       return int'($urandom_range(32768)) - 16384;
      2:       return (int'($urandom_range(4095)) - 2048) * 4096 + int'($urandom_range(2)) - 1;
      default: return int'($urandom_range(2047)) * 4096 + int'($urandom_range(4095));
    endcase
  endfunction

  // Mostly well-formed range lines (first ... last); the rest stray flags
  task automatic add_random(input int count);
    int added;
    int run_len;
    added = 0;
    while (added < count) begin
      if ($urandom_range(99) < 85) begin
        run_len = $urandom_range(1, 24);
        for (int k = 0; k < run_len; k++)
          push_shift(rand_shift(), rand_shift(), k == 0, k == run_len - 1);
        added += run_len;
      end else begin
        push_shift(rand_shift(), rand_shift(), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_shifts.size() != 0 || s_axis_tvalid || weight_sets.size() != 0)
      @(negedge clk_i);
  endtask

  // Register writes only with the block empty
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_RANGE_SAMPLES) range_size = val;
    else if (idx == CFG_AZIMUTH_LINES) azimuth_size = val;
    cfg_valid_i <= 1'b0;
    reg_writes++;
  endtask

  task automatic configure(input logic [SIZE_W-1:0] ranges, input logic [SIZE_W-1:0] lines);
    wait_drained();
    repeat (4) @(posedge clk_i);
    write_reg(CFG_RANGE_SAMPLES, ranges);
    write_reg(CFG_AZIMUTH_LINES, lines);
    @(negedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, reset sizes. Opening item is a last item with no first item
    // since reset, so the bounds come from the reset state.
    push_shift(4096 + 5, -3, 1'b0, 1'b1);
    push_shift(8388607, -8388608, 1'b1, 1'b1);
    push_shift(-8388608, 8388607, 1'b1, 1'b0);
    push_shift(0, 0, 1'b0, 1'b0);
    push_shift(4096, -4096, 1'b0, 1'b0);            // whole samples
    push_shift(1, -1, 1'b0, 1'b0);
    push_shift(4095, -4095, 1'b0, 1'b0);
    push_shift(2048, -2048, 1'b0, 1'b0);
    push_shift(-1, 1, 1'b0, 1'b1);
    push_shift(12345, -777, 1'b1, 1'b0);
    push_shift(-8388608, 8388607, 1'b0, 1'b0);
    push_shift(8388607, -8388608, 1'b0, 1'b1);      // last item moves the minimum itself
    push_shift(0, 0, 1'b1, 1'b1);

    // Smallest image: negative shifts drive the end bounds below zero
    configure(16'd1, 16'd1);
    push_shift(-8388608, -8388608, 1'b1, 1'b1);
    push_shift(-4096, -2048, 1'b1, 1'b1);
    push_shift(-1, -4097, 1'b1, 1'b1);
    push_shift(3 * 4096 + 1, 8388607, 1'b1, 1'b1);
    add_random(430);

    // Largest image, sender idling
    configure(16'hFFFF, 16'hFFFF);
    tx_idle_pct = 60;
    add_random(460);

    // Small random image, receiver stalling
    configure(SIZE_W'($urandom_range(2, 3000)), SIZE_W'($urandom_range(2, 3000)));
    tx_idle_pct  = 0;
    rx_stall_pct = 60;
    add_random(460);

    // Any size, both sides idling; the sender holds off mid-way until empty
    configure(SIZE_W'($urandom_range(1, 65535)), SIZE_W'($urandom_range(1, 65535)));
    tx_idle_pct  = 16;
    rx_stall_pct = 16;
    add_random(250);
    wait_drained();
    add_random(250);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (weight_sets.size() != 0) begin
      $display("%0t: %0d predictions never matched by a result", $time,
               weight_sets.size());
      errors++;
    end
    $display("Sent %0d shift pairs over five size settings and four idle profiles;",
             shifts_sent);
    $display("checked %0d results, %0d with bounds, after %0d register writes.",
             results_seen, bounds_seen, reg_writes);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
